// ===== hdl/gas_sensor_baseline_settling_core_assert.svh =====
// Assertion macros shared by the baseline settling core.
`ifndef GAS_SENSOR_BASELINE_SETTLING_CORE_ASSERT_SVH
`define GAS_SENSOR_BASELINE_SETTLING_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define GSB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define GSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gsb_pkg.sv =====
// Shared types and constants of the baseline settling core.
`default_nettype none

package gsb_pkg;

    localparam int unsigned NCH         = 3;
    localparam int unsigned SAMP_W      = 12;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned TOL_W       = 8;
    localparam int unsigned RECIP_SHIFT = SUM_W + 5;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned PROD_W      = SUM_W + RECIP_W;
    localparam int unsigned CFG_IDX_W   = 2;

    typedef logic [SAMP_W-1:0] t_samp;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [TOL_W-1:0]  t_tol;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_MIN   = 2'd0,
        CFG_ADC_MAX   = 2'd1,
        CFG_TOLERANCE = 2'd2
    } t_cfg_idx;

    // Per-lane stage control, shared by all three channel lanes.
    typedef struct packed {
        logic acc;      // live beat accepted
        logic grp_end;  // this beat closes a group
        logic ld2;      // group event enters the inversion stage
        logic ok1;      // group event completed normally
        logic ld3;      // event enters the ring stage
    } t_lane_ctl;

    // Output register control.
    typedef struct packed {
        logic ld;       // load a result
        logic ok;       // read_ok of that result
        logic take;     // receiver takes the held beat
    } t_out_ctl;

endpackage

`default_nettype wire

// ===== hdl/gsb_lane.sv =====
// One channel lane: group accumulation, inversion, window ring and stability test.
`default_nettype none

module gsb_lane #(
    parameter int unsigned WINDOW = 10,
    parameter int unsigned GROUP  = 8,
    parameter int unsigned PW     = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  gsb_pkg::t_lane_ctl  i_ctl,
    input  wire [PW-1:0]        i_pos,
    input  gsb_pkg::t_samp      i_sample,
    input  gsb_pkg::t_samp      i_adc_min,
    input  gsb_pkg::t_samp      i_adc_max,
    input  gsb_pkg::t_tol       i_tol,
    output logic                o_in_range,
    output logic                o_stable,
    output gsb_pkg::t_samp      o_base
);

    localparam logic [gsb_pkg::RECIP_W-1:0] M_GROUP =
        gsb_pkg::RECIP_W'((2**gsb_pkg::RECIP_SHIFT + GROUP - 1) / GROUP);
    localparam logic [gsb_pkg::RECIP_W-1:0] M_WINDOW =
        gsb_pkg::RECIP_W'((2**gsb_pkg::RECIP_SHIFT + WINDOW - 1) / WINDOW);

    gsb_pkg::t_sum  r_gsum, n_gsum;
    gsb_pkg::t_sum  r_e1_sum, n_e1_sum;
    gsb_pkg::t_samp r_cur, n_cur;
    gsb_pkg::t_samp r_cur3, n_cur3;
    gsb_pkg::t_sum  r_ws, n_ws;
    gsb_pkg::t_samp r_hist [WINDOW];

    gsb_pkg::t_sum                w_add;
    logic [gsb_pkg::PROD_W-1:0]   w_gprod;
    gsb_pkg::t_sum                w_mean;
    logic [gsb_pkg::PROD_W-1:0]   w_wprod;
    gsb_pkg::t_sum                w_avg;
    gsb_pkg::t_sum                w_diff;

    assign o_in_range = (i_sample >= i_adc_min) && (i_sample <= i_adc_max);
    assign w_add      = gsb_pkg::SUM_W'(r_gsum + gsb_pkg::SUM_W'(i_sample));

    // Floor division by constants through reciprocal multiplication.
    assign w_gprod = gsb_pkg::PROD_W'(r_e1_sum) * gsb_pkg::PROD_W'(M_GROUP);
    assign w_mean  = w_gprod[gsb_pkg::RECIP_SHIFT +: gsb_pkg::SUM_W];
    assign w_wprod = gsb_pkg::PROD_W'(r_ws) * gsb_pkg::PROD_W'(M_WINDOW);
    assign w_avg   = w_wprod[gsb_pkg::RECIP_SHIFT +: gsb_pkg::SUM_W];

    always_comb begin
        n_gsum   = r_gsum;
        n_e1_sum = r_e1_sum;
        n_cur    = r_cur;
        n_cur3   = r_cur3;
        n_ws     = r_ws;
        if (i_ctl.acc) begin
            if (i_ctl.grp_end) begin
                n_gsum   = '0;
                n_e1_sum = w_add;
            end else begin
                n_gsum = w_add;
            end
        end
        // Invert only on a completed group; keep the old value otherwise.
        if (i_ctl.ld2 && i_ctl.ok1) begin
            if (w_mean > gsb_pkg::SUM_W'(i_adc_max)) begin
                n_cur = '0;
            end else begin
                n_cur = gsb_pkg::SAMP_W'(gsb_pkg::SUM_W'(i_adc_max) - w_mean);
            end
        end
        if (i_ctl.ld3) begin
            n_ws   = gsb_pkg::SUM_W'(r_ws + gsb_pkg::SUM_W'(r_cur)
                     - gsb_pkg::SUM_W'(r_hist[i_pos]));
            n_cur3 = r_cur;
        end
    end

    always_comb begin
        if (w_avg >= gsb_pkg::SUM_W'(r_cur3)) begin
            w_diff = w_avg - gsb_pkg::SUM_W'(r_cur3);
        end else begin
            w_diff = gsb_pkg::SUM_W'(r_cur3) - w_avg;
        end
    end

    assign o_stable = w_diff < gsb_pkg::SUM_W'(i_tol);
    assign o_base   = w_avg[gsb_pkg::SAMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsum <= '0;
            r_cur  <= '0;
            r_ws   <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_gsum <= n_gsum;
            r_cur  <= n_cur;
            r_ws   <= n_ws;
            if (i_ctl.ld3) begin
                r_hist[i_pos] <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_sum <= n_e1_sum;
        r_cur3   <= n_cur3;
    end

endmodule

`default_nettype wire

// ===== hdl/gsb_merge.sv =====
// Merge stage: combine lane flags and hold the result beat.
`default_nettype none

module gsb_merge (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  gsb_pkg::t_out_ctl   i_ctl,
    input  wire [gsb_pkg::NCH-1:0] i_stable,
    input  gsb_pkg::t_samp      i_base [gsb_pkg::NCH],
    output logic                o_all_stable,
    output logic                o_valid,
    output logic                o_read_ok,
    output logic [gsb_pkg::NCH-1:0] o_stable,
    output logic                o_settled,
    output gsb_pkg::t_samp      o_base [gsb_pkg::NCH]
);

    logic r_valid, n_valid;

    assign o_all_stable = &i_stable;
    assign o_valid      = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.ld) begin
            n_valid = 1'b1;
        end else if (i_ctl.take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            o_read_ok <= i_ctl.ok;
            o_stable  <= i_stable;
            o_settled <= o_all_stable;
            o_base    <= i_base;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gas_sensor_baseline_settling_core.sv =====
// Top level of the gas sensor baseline settling detector.
// Input channel: one beat is a raw 12-bit triple (NO2, NH3, CO) on
// i_sample_*, moved by i_valid/o_ready. One beat per cycle is taken while o_ready is high.
// Output channel: one result beat per finished group (GROUP in-range
// triples, or cut short by the first out-of-range triple), moved by
// o_valid/i_ready. It carries read_ok, per-channel stability, settled and
// the three window averages.
// Path: the beat closing a group passes the group, inversion, ring and
// merge registers before its result shows on o_valid. Three channel lanes run
// side by side through four stages: accumulate, invert, ring push, and
// average/compare; the merge stage holds the result beat.
// Throughput: one input beat per cycle, sustained, as long as results are
// taken; results arrive at most one per input beat.
// Stall: a held result does not block input; the stages behind it keep
// filling until the pipeline is full, then o_ready drops.
// Settled: once a result with settled high is loaded, all later beats are
// taken and dropped, with no further result, until reset.
// Reset (synchronous, active low) clears groups, rings, current values and
// registers (adc_min 0, adc_max 4095, tolerance 2). The config channel is
// always ready; write it only while the block is idle.
`default_nettype none

module gas_sensor_baseline_settling_core #(
    parameter int unsigned WINDOW = 10,
    parameter int unsigned GROUP  = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [11:0]          i_sample_no2,
    input  wire [11:0]          i_sample_nh3,
    input  wire [11:0]          i_sample_co,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_read_ok,
    output logic                o_stable_no2,
    output logic                o_stable_nh3,
    output logic                o_stable_co,
    output logic                o_settled,
    output logic [11:0]         o_base_no2,
    output logic [11:0]         o_base_nh3,
    output logic [11:0]         o_base_co,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [gsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [11:0]          i_cfg_data
);

    localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW = $clog2(GROUP + 1);

    // Configuration registers.
    gsb_pkg::t_samp r_adc_min;
    gsb_pkg::t_samp r_adc_max;
    gsb_pkg::t_tol  r_tol;

    // Shared control state.
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [PW-1:0]  r_pos, n_pos;
    logic           r_fin, n_fin;
    logic           r_v1, n_v1, r_ok1, n_ok1;
    logic           r_v2, n_v2, r_ok2, n_ok2;
    logic           r_v3, n_v3, r_ok3, n_ok3;

    logic           w_acc, w_in_ok, w_grp_end, w_squash;
    logic [CW-1:0]  w_cnt_inc;
    logic           w_ld2, w_ld3, w_ld_out;
    logic           w_free1, w_free2, w_free3, w_out_free;
    logic           w_all_stable;

    gsb_pkg::t_lane_ctl w_lane_ctl;
    gsb_pkg::t_out_ctl  w_out_ctl;

    gsb_pkg::t_samp           w_samp [gsb_pkg::NCH];
    gsb_pkg::t_samp           w_base [gsb_pkg::NCH];
    gsb_pkg::t_samp           w_obase [gsb_pkg::NCH];
    logic [gsb_pkg::NCH-1:0]  w_lane_ok;
    logic [gsb_pkg::NCH-1:0]  w_stable;
    logic [gsb_pkg::NCH-1:0]  w_ostable;

    assign w_samp[0] = i_sample_no2;
    assign w_samp[1] = i_sample_nh3;
    assign w_samp[2] = i_sample_co;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_min <= '0;
            r_adc_max <= '1;
            r_tol     <= gsb_pkg::TOL_W'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gsb_pkg::CFG_ADC_MIN:   r_adc_min <= i_cfg_data;
                gsb_pkg::CFG_ADC_MAX:   r_adc_max <= i_cfg_data;
                gsb_pkg::CFG_TOLERANCE: r_tol     <= i_cfg_data[gsb_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Elastic stage chain: a stage loads when it is empty or its beat moves on.
    always_comb begin
        w_out_free = !o_valid || i_ready;
        w_ld_out   = r_v3 && w_out_free;
        w_free3    = !r_v3 || w_ld_out;
        w_ld3      = r_v2 && w_free3;
        w_free2    = !r_v2 || w_ld3;
        w_ld2      = r_v1 && w_free2;
        w_free1    = !r_v1 || w_ld2;
        o_ready    = r_fin || w_free1;

        w_acc      = i_valid && o_ready && !r_fin;
        w_in_ok    = &w_lane_ok;
        w_cnt_inc  = CW'(r_cnt + 1'b1);
        w_grp_end  = w_acc && (!w_in_ok || (w_cnt_inc == CW'(GROUP)));

        // A settling result kills every later event still in flight.
        w_squash   = w_ld_out && w_all_stable;
        n_fin      = r_fin || w_squash;
    end

    always_comb begin
        n_cnt = r_cnt;
        n_pos = r_pos;
        n_v1  = r_v1;
        n_ok1 = r_ok1;
        n_v2  = r_v2;
        n_ok2 = r_ok2;
        n_v3  = r_v3;
        n_ok3 = r_ok3;
        if (w_acc) begin
            n_cnt = w_grp_end ? '0 : w_cnt_inc;
        end
        if (w_ld3) begin
            n_pos = (r_pos == PW'(WINDOW - 1)) ? '0 : PW'(r_pos + 1'b1);
        end
        if (w_grp_end) begin
            n_v1  = 1'b1;
            n_ok1 = w_in_ok;
        end else if (w_ld2) begin
            n_v1 = 1'b0;
        end
        if (w_ld2) begin
            n_v2  = 1'b1;
            n_ok2 = r_ok1;
        end else if (w_ld3) begin
            n_v2 = 1'b0;
        end
        if (w_ld3) begin
            n_v3  = 1'b1;
            n_ok3 = r_ok2;
        end else if (w_ld_out) begin
            n_v3 = 1'b0;
        end
        if (w_squash) begin
            n_v1 = 1'b0;
            n_v2 = 1'b0;
            n_v3 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
            r_fin <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_pos <= n_pos;
            r_fin <= n_fin;
            r_v1  <= n_v1;
            r_v2  <= n_v2;
            r_v3  <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok1 <= n_ok1;
        r_ok2 <= n_ok2;
        r_ok3 <= n_ok3;
    end

    always_comb begin
        w_lane_ctl.acc     = w_acc;
        w_lane_ctl.grp_end = w_grp_end;
        w_lane_ctl.ld2     = w_ld2;
        w_lane_ctl.ok1     = r_ok1;
        w_lane_ctl.ld3     = w_ld3;
        w_out_ctl.ld       = w_ld_out;
        w_out_ctl.ok       = r_ok3;
        w_out_ctl.take     = i_ready;
    end

    // One lane per gas channel.
    for (genvar g = 0; g < gsb_pkg::NCH; g++) begin : g_lane
        gsb_lane #(
            .WINDOW (WINDOW),
            .GROUP  (GROUP),
            .PW     (PW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_lane_ctl),
            .i_pos      (r_pos),
            .i_sample   (w_samp[g]),
            .i_adc_min  (r_adc_min),
            .i_adc_max  (r_adc_max),
            .i_tol      (r_tol),
            .o_in_range (w_lane_ok[g]),
            .o_stable   (w_stable[g]),
            .o_base     (w_base[g])
        );
    end

    gsb_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_out_ctl),
        .i_stable     (w_stable),
        .i_base       (w_base),
        .o_all_stable (w_all_stable),
        .o_valid      (o_valid),
        .o_read_ok    (o_read_ok),
        .o_stable     (w_ostable),
        .o_settled    (o_settled),
        .o_base       (w_obase)
    );

    assign o_stable_no2 = w_ostable[0];
    assign o_stable_nh3 = w_ostable[1];
    assign o_stable_co  = w_ostable[2];
    assign o_base_no2   = w_obase[0];
    assign o_base_nh3   = w_obase[1];
    assign o_base_co    = w_obase[2];

`include "gas_sensor_baseline_settling_core_assert.svh"

    // Once finished, no group event may remain in flight.
    `GSB_ASSERT_SAME(a_fin_flushed, r_fin, !r_v1 && !r_v2 && !r_v3, "event alive after settle")
    // A settled result beat only stands once the block is finished.
    `GSB_ASSERT_SAME(a_settled_fin, o_valid && o_settled, r_fin, "settled beat without finish")
    // The group counter wraps before it reaches the group length.
    `GSB_ASSERT_SAME(a_cnt_range, 1'b1, r_cnt < CW'(GROUP), "group count overrun")
    // Nothing new reaches the output after the block has finished.
    `GSB_ASSERT_NEXT(a_no_late_load, r_fin && !o_valid, !o_valid, "result after settle")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the gas sensor baseline settling core, with its own predictor.
`default_nettype none

module tb;

    // Block sizes; these must match the defaults of the core.
    localparam int unsigned WINDOW = 10;
    localparam int unsigned GROUP  = 8;

    // After the last result, wait DRAIN_CYCLES before treating the core as drained.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_IDLE     = 14;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    localparam gsb_pkg::t_samp SAMP_LO = 12'd0;
    localparam gsb_pkg::t_samp SAMP_HI = 12'd4095;

    // Index 3 is decoded by no register; writes to it must change nothing.
    localparam logic [gsb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Channel order inside a triple: 0 NO2, 1 NH3, 2 CO.
    typedef gsb_pkg::t_samp [gsb_pkg::NCH-1:0] t_triple;

    typedef enum {
        DRAW_SPREAD,    // uniform over the configured valid range, or over all codes if lo > hi
        DRAW_STEADY,    // small jitter around a per-channel level
        DRAW_WILD       // anything a 12-bit ADC can produce
    } t_draw;

    // Everything the core keeps between beats, plus its registers.
    typedef struct packed {
        gsb_pkg::t_sum  [gsb_pkg::NCH-1:0]             grp_sum;
        logic           [4:0]                          grp_cnt;
        t_triple                                       cur;
        gsb_pkg::t_samp [gsb_pkg::NCH-1:0][WINDOW-1:0] ring;
        gsb_pkg::t_sum  [gsb_pkg::NCH-1:0]             win_sum;
        logic           [3:0]                          slot;
        logic                                          done;
        gsb_pkg::t_samp                                lo;
        gsb_pkg::t_samp                                hi;
        gsb_pkg::t_tol                                 tol;
    } t_calib;

    // One result beat as the core should present it.
    typedef struct packed {
        logic                    ok;
        logic [gsb_pkg::NCH-1:0] stable;
        logic                    settled;
        t_triple                 base;
    } t_report;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          o_ready;
    gsb_pkg::t_samp                i_sample_no2 = '0;
    gsb_pkg::t_samp                i_sample_nh3 = '0;
    gsb_pkg::t_samp                i_sample_co  = '0;
    logic                          o_valid;
    logic                          i_ready      = 1'b0;
    logic                          o_read_ok;
    logic                          o_stable_no2;
    logic                          o_stable_nh3;
    logic                          o_stable_co;
    logic                          o_settled;
    gsb_pkg::t_samp                o_base_no2;
    gsb_pkg::t_samp                o_base_nh3;
    gsb_pkg::t_samp                o_base_co;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [gsb_pkg::CFG_IDX_W-1:0] i_cfg_index  = gsb_pkg::CFG_ADC_MIN;
    gsb_pkg::t_samp                i_cfg_data   = '0;

    t_calib      calib;
    t_report     expected_reports[$];
    bit          pace_src  = 1'b1;
    bit          pace_sink = 1'b1;
    int unsigned beats_sent      = 0;
    int unsigned reports_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned aborted_groups  = 0;
    int unsigned settled_seen    = 0;
    int unsigned stable_hits [gsb_pkg::NCH];
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;

    gas_sensor_baseline_settling_core #(
        .WINDOW(WINDOW),
        .GROUP (GROUP)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_no2(i_sample_no2),
        .i_sample_nh3(i_sample_nh3),
        .i_sample_co (i_sample_co),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_read_ok   (o_read_ok),
        .o_stable_no2(o_stable_no2),
        .o_stable_nh3(o_stable_nh3),
        .o_stable_co (o_stable_co),
        .o_settled   (o_settled),
        .o_base_no2  (o_base_no2),
        .o_base_nh3  (o_base_nh3),
        .o_base_co   (o_base_co),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[gas_sensor_baseline_settling_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: advance the calibration state by one accepted triple.
    // Returns 1 when the triple closes a group and so yields a result.
    // ------------------------------------------------------------------
    function automatic logic advance_calibration(inout t_calib m, input t_triple s,
                                                 output t_report r);
        logic        in_ok;
        int unsigned pos;
        int unsigned mean;
        int unsigned avg;
        int          delta;
        int          c;
        r = '0;
        // Once settled, beats are swallowed until reset.
        if (m.done)
            return 1'b0;
        in_ok = 1'b1;
        for (c = 0; c < gsb_pkg::NCH; c++)
            if (s[c] < m.lo || s[c] > m.hi)
                in_ok = 1'b0;
        if (in_ok) begin
            for (c = 0; c < gsb_pkg::NCH; c++)
                m.grp_sum[c] = m.grp_sum[c] + gsb_pkg::t_sum'(s[c]);
            m.grp_cnt = m.grp_cnt + 5'd1;
            if (m.grp_cnt < GROUP)
                return 1'b0;
            // Invert around adc_max; clamp at zero if the max dropped below the mean.
            for (c = 0; c < gsb_pkg::NCH; c++) begin
                mean = m.grp_sum[c] / GROUP;
                m.cur[c] = (mean > m.hi) ? SAMP_LO
                                         : gsb_pkg::t_samp'(int'(m.hi) - int'(mean));
            end
        end
        // A failed group keeps the old current values but still pushes them.
        r.ok      = in_ok;
        m.grp_sum = '0;
        m.grp_cnt = '0;
        pos = (m.slot >= WINDOW) ? 0 : m.slot;
        for (c = 0; c < gsb_pkg::NCH; c++) begin
            m.win_sum[c] = gsb_pkg::t_sum'(int'(m.win_sum[c]) + int'(m.cur[c])
                                          - int'(m.ring[c][pos]));
            m.ring[c][pos] = m.cur[c];
            avg   = m.win_sum[c] / WINDOW;
            delta = int'(avg) - int'(m.cur[c]);
            if (delta < 0)
                delta = -delta;
            r.stable[c] = (delta < int'(m.tol));
            r.base[c]   = gsb_pkg::t_samp'(avg);
        end
        m.slot    = 4'((pos + 1) % WINDOW);
        m.done    = &r.stable;
        r.settled = m.done;
        return 1'b1;
    endfunction

    function automatic t_triple make_triple(input gsb_pkg::t_samp no2,
                                            input gsb_pkg::t_samp nh3,
                                            input gsb_pkg::t_samp co);
        t_triple s;
        s[0] = no2;
        s[1] = nh3;
        s[2] = co;
        return s;
    endfunction

    function automatic t_triple pick_levels();
        t_triple s;
        int      c;
        for (c = 0; c < gsb_pkg::NCH; c++)
            s[c] = gsb_pkg::t_samp'($urandom_range(300, 3800));
        return s;
    endfunction

    function automatic t_triple draw_triple(input t_draw how, input t_triple levels);
        t_triple s;
        int      v;
        int      c;
        for (c = 0; c < gsb_pkg::NCH; c++) begin
            case (how)
                DRAW_SPREAD: begin
                    if (calib.lo <= calib.hi)
                        s[c] = gsb_pkg::t_samp'($urandom_range(calib.lo, calib.hi));
                    else
                        s[c] = gsb_pkg::t_samp'($urandom_range(0, SAMP_HI));
                end
                DRAW_STEADY: begin
                    v = int'(levels[c]) + int'($urandom_range(0, 6)) - 3;
                    if (v < 0)
                        v = 0;
                    if (v > int'(SAMP_HI))
                        v = int'(SAMP_HI);
                    s[c] = gsb_pkg::t_samp'(v);
                end
                default: begin
                    s[c] = gsb_pkg::t_samp'($urandom_range(0, SAMP_HI));
                end
            endcase
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one triple, hold it until taken, then predict.
    // Valid stays high on return; the next call either replaces the
    // payload in the same step or drops valid for an idle gap.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_triple s);
        int unsigned gap;
        t_report     rep;
        gap = (pace_src && $urandom_range(0, 3) != 0) ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sample_no2 <= s[0];
        i_sample_nh3 <= s[1];
        i_sample_co  <= s[2];
        do @(posedge i_clk); while (o_ready !== 1'b1);
        beats_sent++;
        if (advance_calibration(calib, s, rep))
            expected_reports.push_back(rep);
    endtask

    // Drop valid, wait until every predicted result has been taken, then
    // let the pipeline drain beats that close no group.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gsb_pkg::CFG_IDX_W-1:0] idx,
                             input gsb_pkg::t_samp val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            gsb_pkg::CFG_ADC_MIN:   calib.lo  = val;
            gsb_pkg::CFG_ADC_MAX:   calib.hi  = val;
            gsb_pkg::CFG_TOLERANCE: calib.tol = val[gsb_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits above the 8-bit tolerance get random junk; the core drops them.
    task automatic configure(input gsb_pkg::t_samp lo, input gsb_pkg::t_samp hi,
                             input gsb_pkg::t_tol tol);
        write_reg(gsb_pkg::CFG_ADC_MIN, lo);
        write_reg(gsb_pkg::CFG_ADC_MAX, hi);
        write_reg(gsb_pkg::CFG_TOLERANCE, {4'($urandom_range(0, 15)), tol});
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall before each result, then take it.
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int unsigned stall;
        forever begin
            stall = (pace_sink && $urandom_range(0, 3) != 0) ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && o_valid === 1'b1));
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                $display({"%0t unexpected result beat: expected none ",
                          "actual read_ok %0d base %0d/%0d/%0d"},
                         $time, o_read_ok, o_base_no2, o_base_nh3, o_base_co);
            end else begin
                want = expected_reports.pop_front();
                check_field("read_ok",    want.ok,        o_read_ok);
                check_field("stable_no2", want.stable[0], o_stable_no2);
                check_field("stable_nh3", want.stable[1], o_stable_nh3);
                check_field("stable_co",  want.stable[2], o_stable_co);
                check_field("settled",    want.settled,   o_settled);
                check_field("base_no2",   want.base[0],   o_base_no2);
                check_field("base_nh3",   want.base[1],   o_base_nh3);
                check_field("base_co",    want.base[2],   o_base_co);
                reports_checked++;
                if (!want.ok)
                    aborted_groups++;
                if (want.settled)
                    settled_seen++;
                for (int c = 0; c < gsb_pkg::NCH; c++)
                    if (want.stable[c])
                        stable_hits[c]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Random phase: one register setting, then a stream of triples.
    // Triples that would settle the core early are redrawn, since the core
    // only leaves the settled state through reset.
    // ------------------------------------------------------------------
    task automatic run_phase(input gsb_pkg::t_samp lo, input gsb_pkg::t_samp hi,
                             input gsb_pkg::t_tol tol,
                             input t_draw how, input int unsigned count,
                             input int unsigned noise_odds, input bit src_paced,
                             input bit sink_paced);
        t_triple     s;
        t_triple     levels;
        t_calib      trial;
        t_report     rep;
        int unsigned tries;
        configure(lo, hi, tol);
        pace_src  = src_paced;
        pace_sink = sink_paced;
        levels    = pick_levels();
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39)
                levels = pick_levels();
            // Hold off the sender now and then until all results are back.
            if (n == count / 2 || $urandom_range(0, 63) == 0)
                wait_idle();
            tries = 0;
            do begin
                s = draw_triple((tries == 0) ? how : DRAW_WILD, levels);
                // Break the sequence: one channel takes any raw value.
                if (tries == 0 && noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
                    s[$urandom_range(0, gsb_pkg::NCH - 1)] =
                        gsb_pkg::t_samp'($urandom_range(0, SAMP_HI));
                trial = calib;
                void'(advance_calibration(trial, s, rep));
                tries++;
            end while (trial.done && !calib.done && tries < 64);
            send_beat(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: full range, tolerance 2. One group of rail values.
    task automatic test_defaults_after_reset();
        for (int k = 0; k < GROUP; k++)
            send_beat(make_triple((k % 2 == 1) ? SAMP_HI : SAMP_LO,
                                  (k % 2 == 1) ? SAMP_LO : SAMP_HI,
                                  (k < GROUP / 2) ? SAMP_HI : SAMP_LO));
    endtask

    // Window bounds are inclusive; any one channel out of range ends the group
    // as failed and throws the partial sums away. Zero tolerance keeps every
    // channel unstable. The unused register index must be ignored.
    task automatic test_out_of_range_abort();
        configure(12'd100, 12'd3000, 8'd0);
        write_reg(CFG_SPARE, 12'h5A5);
        send_beat(make_triple(12'd100, 12'd3000, 12'd1500));
        send_beat(make_triple(12'd3000, 12'd100, 12'd2000));
        send_beat(make_triple(12'd99, 12'd500, 12'd500));
        send_beat(make_triple(12'd500, 12'd3001, 12'd500));
        send_beat(make_triple(12'd500, 12'd500, SAMP_HI));
    endtask

    // adc_min above adc_max: no sample is valid, each triple fails a group.
    task automatic test_inverted_range();
        configure(12'd3000, 12'd100, 8'd0);
        send_beat(make_triple(12'd2000, 12'd2000, 12'd2000));
        send_beat(make_triple(12'd50, 12'd3500, 12'd100));
    endtask

    // Lower adc_max in the middle of a group so the mean ends up above it;
    // the current values must clamp at zero.
    task automatic test_mean_above_max();
        configure(SAMP_LO, SAMP_HI, 8'd0);
        for (int k = 0; k < GROUP / 2; k++)
            send_beat(make_triple(12'd4000, SAMP_HI, 12'd3900));
        write_reg(gsb_pkg::CFG_ADC_MAX, 12'd100);
        for (int k = 0; k < GROUP / 2; k++)
            send_beat(make_triple(12'd100, SAMP_LO, 12'd50));
    endtask

    task automatic test_random_traffic();
        gsb_pkg::t_samp lo;
        gsb_pkg::t_samp hi;
        gsb_pkg::t_tol  tol;
        // Full range at the widest tolerance: stability flags come and go.
        run_phase(SAMP_LO, SAMP_HI, 8'd255, DRAW_SPREAD, 160, 0, 1'b1, 1'b1);
        // Narrowed range with out-of-range noise, receiver never stalls.
        lo = gsb_pkg::t_samp'($urandom_range(0, 1000));
        hi = gsb_pkg::t_samp'($urandom_range(3000, SAMP_HI));
        run_phase(lo, hi, gsb_pkg::t_tol'($urandom_range(0, 3)), DRAW_SPREAD, 200, 10,
                  1'b1, 1'b0);
        // Single-point ranges at both rails, back to back.
        run_phase(SAMP_LO, SAMP_LO, 8'd0, DRAW_SPREAD, 60, 6, 1'b0, 1'b0);
        run_phase(SAMP_HI, SAMP_HI, 8'd0, DRAW_SPREAD, 60, 6, 1'b0, 1'b1);
        // Inverted range: every beat fails its group.
        lo = gsb_pkg::t_samp'($urandom_range(2049, SAMP_HI));
        hi = gsb_pkg::t_samp'($urandom_range(0, 2048));
        run_phase(lo, hi, 8'd0, DRAW_SPREAD, 50, 0, 1'b1, 1'b1);
        // Arbitrary range; a narrow one gets zero tolerance so it cannot settle.
        lo  = gsb_pkg::t_samp'($urandom_range(0, SAMP_HI));
        hi  = gsb_pkg::t_samp'($urandom_range(lo, SAMP_HI));
        tol = (int'(hi) - int'(lo) >= 1024) ? gsb_pkg::t_tol'($urandom_range(0, 255)) : 8'd0;
        run_phase(lo, hi, tol, DRAW_SPREAD, 220, 12, 1'b1, 1'b1);
        // Steady levels: channels approach stability one by one.
        run_phase(SAMP_LO, SAMP_HI, gsb_pkg::t_tol'($urandom_range(10, 60)), DRAW_STEADY,
                  180, 20, 1'b1, 1'b1);
    endtask

    // Feed steady levels until all three channels settle, then check that
    // later beats are taken without any result, and write a register after.
    task automatic test_settle_then_freeze();
        t_triple     levels;
        int unsigned n;
        configure(SAMP_LO, SAMP_HI, 8'd40);
        pace_src  = 1'b1;
        pace_sink = 1'b1;
        levels    = pick_levels();
        n = 0;
        while (!calib.done && n < 400) begin
            send_beat(draw_triple(DRAW_STEADY, levels));
            n++;
        end
        for (int k = 0; k < 12; k++)
            send_beat(draw_triple(DRAW_WILD, levels));
        write_reg(gsb_pkg::CFG_ADC_MIN, gsb_pkg::t_samp'($urandom_range(0, SAMP_HI)));
    endtask

    initial begin
        // Predictor starts from the reset state of the core.
        calib     = '0;
        calib.hi  = SAMP_HI;
        calib.tol = 8'd2;
        for (int c = 0; c < gsb_pkg::NCH; c++)
            stable_hits[c] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_after_reset();
        test_out_of_range_abort();
        test_inverted_range();
        test_mean_above_max();
        test_random_traffic();
        test_settle_then_freeze();

        // Drain: all predictions taken, then DRAIN_CYCLES more for strays.
        wait_idle();

        $display("run covered %0d input beats, %0d result beats (%0d aborted groups), %0d writes",
                 beats_sent, reports_checked, aborted_groups, reg_writes);
        $display("stable results no2/nh3/co %0d/%0d/%0d, settled %0d, mismatches %0d",
                 stable_hits[0], stable_hits[1], stable_hits[2], settled_seen, mismatches);
        if (mismatches == 0)
            $display("[gas_sensor_baseline_settling_core] OK");
        else
            $display("[gas_sensor_baseline_settling_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
